### sv/ukf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ukf_pkg;

    localparam int DEPTH = 128;
    localparam int KEY_W = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OP_W = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W = 8;
    localparam int OCC_W = 8;
    localparam int IN_W = 40;
    localparam int OUT_W = 56;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

    typedef struct packed {
        logic cmp_en;
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

`default_nettype wire

### sv/ukf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ukf_cell
    import ukf_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire cell_ctl_t   ctl,
    input  wire              occupied,
    input  wire [KEY_W-1:0]  key_in,
    input  wire [KEY_W-1:0]  next_key,
    output logic [KEY_W-1:0] key_out,
    output logic             match
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             match_reg;
    logic             match_next;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.load)
        begin
            key_next = key_in;
        end
        else if (ctl.shift)
        begin
            key_next = next_key;
        end
        match_next = match_reg;
        if (ctl.cmp_en)
        begin
            match_next = occupied && (key_reg == key_in);
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign key_out = key_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

### sv/ukf_enc.sv
`timescale 1ns / 1ps
`default_nettype none

module ukf_enc
    import ukf_pkg::*;
(
    input  wire [DEPTH-1:0]  match,
    output logic             hit,
    output logic [IDX_W-1:0] index
);

    // Keys are unique, so at most one cell matches and an OR of indices suffices.
    always_comb
    begin
        index = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match[i])
            begin
                index = index | IDX_W'(i);
            end
        end
        hit = |match;
    end

endmodule

`default_nettype wire

### sv/unique_key_fifo_with_position_lookup.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload (tdata, lowest bit first)
// s_axis    in         op[1:0], key[33:2], zero fill to 40 bits
// m_axis    out        status[2:0], position[10:3], served_key[42:11],
//                      occupancy[50:43], zero fill to 56 bits
//
// Each item is accepted in S_IDLE, every cell compares its key in S_CMP, and in
// S_EXEC the match is encoded and the cell row is shifted or loaded.
// The execute cycle waits while a result held in the output register is not being taken.
// One item is in flight at a time; the next is accepted once the current
// one has reached the output register. Reset empties the queue.

module unique_key_fifo_with_position_lookup
    import ukf_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire [IN_W-1:0]  s_axis_tdata,   // op, key
    output logic            m_axis_tvalid,
    input  wire             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // status, position, served_key, occupancy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [OP_W-1:0]  op_reg;
    logic [OP_W-1:0]  op_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;

    logic [KEY_W-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] occupied;
    logic [DEPTH-1:0] load_vec;
    cell_ctl_t        cell_ctl [DEPTH];

    logic             hit;
    logic [IDX_W-1:0] hit_index;
    logic             go;
    logic             do_shift;
    logic             do_load;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    served_key;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    assign go = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);

    ukf_enc u_enc
    (
        .match (match),
        .hit   (hit),
        .index (hit_index)
    );

    always_comb
    begin
        status = ST_OK;
        position = '0;
        served_key = '0;
        count_next = count_reg;
        do_shift = 1'b0;
        do_load = 1'b0;
        case (op_reg)
            OP_LOOKUP:
            begin
                if (hit)
                begin
                    position = POS_W'({1'b0, hit_index} + (IDX_W + 1)'(1));
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            OP_DEQUEUE:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    served_key = cell_key[0];
                    do_shift = go;
                    count_next = go ? count_reg - CNT_W'(1) : count_reg;
                end
            end
            OP_ENQUEUE:
            begin
                if (hit)
                begin
                    status = ST_DUPLICATE;
                end
                else if (count_reg == CNT_W'(DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_load = go;
                    count_next = go ? count_reg + CNT_W'(1) : count_reg;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occupied[i] = (CNT_W'(i) < count_reg);
        assign load_vec[i] = do_load && (count_reg == CNT_W'(i));
        assign cell_ctl[i].cmp_en = (state_reg == S_CMP);
        assign cell_ctl[i].shift = do_shift;
        assign cell_ctl[i].load = load_vec[i];

        if (i == DEPTH - 1)
        begin : g_last
            ukf_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl[i]),
                .occupied (occupied[i]),
                .key_in   (key_reg),
                .next_key (key_reg),
                .key_out  (cell_key[i]),
                .match    (match[i])
            );
        end
        else
        begin : g_mid
            ukf_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl[i]),
                .occupied (occupied[i]),
                .key_in   (key_reg),
                .next_key (cell_key[i+1]),
                .key_out  (cell_key[i]),
                .match    (match[i])
            );
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        key_next = key_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next = s_axis_tdata[OP_W-1:0];
                    key_next = s_axis_tdata[OP_W +: KEY_W];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (go)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = OUT_W'({OCC_W'(count_next), served_key, position, status});
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_reg <= key_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("Queue count exceeds the depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot0(match))
        else $error("More than one cell holds the same key.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("Result appeared without an execute cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_CMP))
        else $error("Accepted item did not enter the compare cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> (count_reg == $past(count_reg)))
        else $error("Count changed outside the execute cycle.");
`endif

endmodule

`default_nettype wire
